@@ sv/pttm_pkg.sv @@
// package: shared types and constants of the pulse train template matcher
package pttm_pkg;
   localparam int ENTRIES_DEF    = 16;
   localparam int MAX_PULSES_DEF = 512;
   localparam int PULSE_BITS_DEF = 20;
   localparam int FOOTER_LIMIT   = 9999;
   localparam int DEFAULT_TOL    = 30;

   typedef enum logic [1:0] {
      OP_TEMPLATE = 2'd0,
      OP_ATTR     = 2'd1,
      OP_PULSE    = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP_EVAL,
      ST_SEARCH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_template;
      logic load_attr;
      logic cmp_start;
      logic cmp_read;
      logic cmp_eval;
      logic search_start;
      logic search_step;
      logic frame_clear;
      logic pulse_done;
   } cmd_type;

   typedef struct packed {
      logic cmp_last;
      logic search_done;
      logic overflow_now;
   } status_type;
endpackage

@@ sv/pttm_ctrl.sv @@
// controller: sequences template loads, per-pulse code compares and the frame search
module pttm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic                req_last_pulse,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pttm_pkg::status_type sts,
   output pttm_pkg::cmd_type    cmd
);
   pttm_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;
   logic acc;

   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pttm_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      case (state_ff)
         pttm_pkg::ST_IDLE: begin
            if (acc && req_opcode == pttm_pkg::OP_PULSE) begin
               last_in = req_last_pulse;
               if (sts.overflow_now) begin
                  state_in = req_last_pulse ? pttm_pkg::ST_SEARCH : pttm_pkg::ST_IDLE;
               end else begin
                  state_in = pttm_pkg::ST_CMP_RD;
               end
            end
         end
         pttm_pkg::ST_CMP_RD: state_in = pttm_pkg::ST_CMP_EVAL;
         pttm_pkg::ST_CMP_EVAL: begin
            if (sts.cmp_last) begin
               state_in = last_ff ? pttm_pkg::ST_SEARCH : pttm_pkg::ST_IDLE;
            end else begin
               state_in = pttm_pkg::ST_CMP_RD;
            end
         end
         pttm_pkg::ST_SEARCH: begin
            if (sts.search_done) state_in = pttm_pkg::ST_OUT;
         end
         pttm_pkg::ST_OUT: begin
            if (rsp_ready) state_in = pttm_pkg::ST_IDLE;
         end
         default: state_in = pttm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == pttm_pkg::ST_IDLE);
      rsp_valid = (state_ff == pttm_pkg::ST_OUT);
      cmd = '0;
      cmd.load_template = acc && req_opcode == pttm_pkg::OP_TEMPLATE;
      cmd.load_attr     = acc && req_opcode == pttm_pkg::OP_ATTR;
      cmd.cmp_start     = acc && req_opcode == pttm_pkg::OP_PULSE;
      cmd.search_start  = acc && req_opcode == pttm_pkg::OP_PULSE && sts.overflow_now
                          && req_last_pulse;
      case (state_ff)
         pttm_pkg::ST_CMP_RD: cmd.cmp_read = 1'b1;
         pttm_pkg::ST_CMP_EVAL: begin
            cmd.cmp_eval = 1'b1;
            cmd.pulse_done = sts.cmp_last;
            cmd.search_start = sts.cmp_last && last_ff;
         end
         pttm_pkg::ST_SEARCH: cmd.search_step = 1'b1;
         pttm_pkg::ST_OUT: cmd.frame_clear = rsp_ready;
         default: ;
      endcase
   end
endmodule

@@ sv/pttm_datapath.sv @@
// datapath: template memory, entry attributes, pulse compare and match search
module pttm_datapath #(
   parameter int ENTRIES    = pttm_pkg::ENTRIES_DEF,
   parameter int MAX_PULSES = pttm_pkg::MAX_PULSES_DEF,
   parameter int PULSE_BITS = pttm_pkg::PULSE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3:0]            req_entry,
   input  logic                  req_code_select,
   input  logic [8:0]            req_pulse_index,
   input  logic [19:0]           req_pulse_value,
   input  logic [23:0]           req_device_id,
   input  logic [6:0]            req_tolerance,
   input  logic [9:0]            req_code_length,
   input  logic                  req_last_pulse,
   input  pttm_pkg::cmd_type     cmd,
   output pttm_pkg::status_type  sts,
   output logic                  rsp_found,
   output logic [3:0]            rsp_matched_entry,
   output logic [23:0]           rsp_device_id_out,
   output logic                  rsp_switch_on,
   output logic                  rsp_frame_overflow
);
   localparam int CODES = 2 * ENTRIES;
   localparam int CB    = $clog2(CODES);
   localparam int EB    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PB    = $clog2(MAX_PULSES);
   localparam int FB    = $clog2(MAX_PULSES + 1);
   localparam int AB    = CB + PB;

   logic [PULSE_BITS-1:0] tmem [CODES*MAX_PULSES];
   logic [23:0] dev_ff [ENTRIES];
   logic [6:0]  tol_ff [ENTRIES];
   logic [9:0]  len_ff [CODES];
   logic [CODES-1:0] mis_ff;
   logic [FB-1:0] cnt_ff;
   logic ovf_ff;
   logic [CB-1:0] code_ff;
   logic [PULSE_BITS-1:0] val_ff, rd_ff;
   logic last_ff;
   logic [9:0] clen_ff;
   logic [6:0] ctol_ff;
   logic found_ff, sw_ff;
   logic [3:0] ment_ff;
   logic [23:0] mdev_ff;

   logic ent_ok, idx_ok, code_hit;
   logic [31:0] ext_ent;
   logic [PB-1:0] pos;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [PULSE_BITS-1:0] lo, hi;
   logic signed [PULSE_BITS+8:0] lhs, rhs;
   logic skip, pair_ok, active;
   logic [EB-1:0] cur_ent;

   assign ext_ent = {28'd0, req_entry};
   assign ent_ok  = ext_ent < ENTRIES;
   assign idx_ok  = {23'd0, req_pulse_index} < MAX_PULSES;
   assign pos     = cnt_ff[PB-1:0];
   assign wr_addr = AB'((({27'd0, req_entry, req_code_select}) * MAX_PULSES)
                       + {23'd0, req_pulse_index});
   assign rd_addr = AB'(({{(32-CB){1'b0}}, code_ff} * MAX_PULSES)
                       + {{(32-PB){1'b0}}, pos});
   assign cur_ent = EB'(code_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.load_template && ent_ok && idx_ok) tmem[wr_addr] <= req_pulse_value[PULSE_BITS-1:0];
      if (cmd.cmp_read) rd_ff <= tmem[rd_addr];
   end

   assign lo  = (rd_ff < val_ff) ? rd_ff : val_ff;
   assign hi  = (rd_ff < val_ff) ? val_ff : rd_ff;
   assign lhs = $signed({9'd0, lo}) * 29'sd100;
   assign rhs = $signed({9'd0, hi}) * ($signed(8'sd99) - $signed({1'b0, ctol_ff}));
   assign pair_ok = (hi == '0) || (lhs > rhs);
   assign active  = 11'(cnt_ff) < {1'b0, clen_ff};
   assign skip = last_ff && (11'(cnt_ff) + 11'd1 == {1'b0, clen_ff}) &&
                 (32'(rd_ff) > pttm_pkg::FOOTER_LIMIT ||
                  32'(val_ff) > pttm_pkg::FOOTER_LIMIT);
   assign code_hit = (11'(cnt_ff) == {1'b0, len_ff[code_ff]}) && !mis_ff[code_ff];

   assign sts.cmp_last     = (code_ff == CB'(CODES - 1));
   assign sts.search_done  = ovf_ff || code_hit || (code_ff == CB'(CODES - 2));
   assign sts.overflow_now = ({{(32-FB){1'b0}}, cnt_ff} >= MAX_PULSES);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dev_ff[i] <= '0;
            tol_ff[i] <= 7'(pttm_pkg::DEFAULT_TOL);
         end
         for (int i = 0; i < CODES; i++) len_ff[i] <= '0;
         mis_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         code_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.load_attr && ent_ok) begin
            dev_ff[EB'(req_entry)] <= req_device_id;
            tol_ff[EB'(req_entry)] <= req_tolerance;
            len_ff[CB'({req_entry, req_code_select})] <= req_code_length;
         end
         if (cmd.cmp_start) begin
            val_ff  <= req_pulse_value[PULSE_BITS-1:0];
            last_ff <= req_last_pulse;
            code_ff <= '0;
            if (sts.overflow_now) ovf_ff <= 1'b1;
         end
         if (cmd.cmp_read) begin
            clen_ff <= len_ff[code_ff];
            ctol_ff <= tol_ff[cur_ent];
         end
         if (cmd.cmp_eval) begin
            if (active && !skip && !pair_ok) mis_ff[code_ff] <= 1'b1;
            code_ff <= code_ff + CB'(1);
         end
         if (cmd.pulse_done) cnt_ff <= cnt_ff + FB'(1);
         if (cmd.search_start) begin
            code_ff  <= CB'(1);
            found_ff <= 1'b0;
         end
         if (cmd.search_step) begin
            if (!ovf_ff && code_hit) begin
               found_ff <= 1'b1;
               ment_ff  <= 4'(cur_ent);
               mdev_ff  <= dev_ff[cur_ent];
               sw_ff    <= code_ff[0];
            end else if (code_ff[0]) begin
               code_ff <= code_ff - CB'(1);
            end else begin
               code_ff <= code_ff + CB'(3);
            end
         end
         if (cmd.frame_clear) begin
            mis_ff <= '0;
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_matched_entry  = found_ff ? ment_ff : 4'd0;
   assign rsp_device_id_out  = found_ff ? mdev_ff : 24'd0;
   assign rsp_switch_on      = found_ff ? sw_ff : 1'b0;
   assign rsp_frame_overflow = ovf_ff;
endmodule

@@ sv/pulse_train_template_matcher.sv @@
// top level: pulse train template matcher
// a received pulse gets one memory read and one compare per stored code,
// sequenced through the template memory port, unless the frame has already overflowed
// a closing pulse adds a search over the entries, switch-on code first, then the output state
// load words need no clearing pass; tables are ready right after reset
// synchronous active-high reset clears attributes, lengths and frame state
module pulse_train_template_matcher #(
   parameter int ENTRIES    = pttm_pkg::ENTRIES_DEF,
   parameter int MAX_PULSES = pttm_pkg::MAX_PULSES_DEF,
   parameter int PULSE_BITS = pttm_pkg::PULSE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_entry,
   input  logic        req_code_select,
   input  logic [8:0]  req_pulse_index,
   input  logic [19:0] req_pulse_value,
   input  logic [23:0] req_device_id,
   input  logic [6:0]  req_tolerance,
   input  logic [9:0]  req_code_length,
   input  logic        req_last_pulse,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [3:0]  rsp_matched_entry,
   output logic [23:0] rsp_device_id_out,
   output logic        rsp_switch_on,
   output logic        rsp_frame_overflow
);
   pttm_pkg::cmd_type    cmd;
   pttm_pkg::status_type sts;

   pttm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_last_pulse,
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   pttm_datapath #(.ENTRIES(ENTRIES), .MAX_PULSES(MAX_PULSES), .PULSE_BITS(PULSE_BITS))
   u_dp (
      .clock, .reset, .req_entry, .req_code_select, .req_pulse_index, .req_pulse_value,
      .req_device_id, .req_tolerance, .req_code_length, .req_last_pulse, .cmd, .sts,
      .rsp_found, .rsp_matched_entry, .rsp_device_id_out, .rsp_switch_on,
      .rsp_frame_overflow
   );
endmodule

@@ sv/pttm_checker.sv @@
// checker: port-level properties of the pulse train template matcher, with bind
module pttm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [3:0]  rsp_matched_entry,
   input logic [23:0] rsp_device_id_out,
   input logic        rsp_frame_overflow
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found))
      else $error("result word dropped or changed while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result waits");
   a_ovf_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_overflow |-> !rsp_found)
      else $error("overflowed frame reported a match");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_matched_entry == 4'd0 && rsp_device_id_out == 24'd0)
      else $error("miss result carries entry data");
endmodule

bind pulse_train_template_matcher pttm_checker u_pttm_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_found,
   .rsp_matched_entry, .rsp_device_id_out, .rsp_frame_overflow
);

@@ tb/tb_pulse_train_template_matcher.sv @@
// testbench: pulse train template matcher checked against a built-in predictor
module tb_pulse_train_template_matcher;
   localparam int CODES = 2 * pttm_pkg::ENTRIES_DEF;
   localparam int MAXP = pttm_pkg::MAX_PULSES_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        found;
      logic [3:0]  matched_entry;
      logic [23:0] device_id_out;
      logic        switch_on;
      logic        frame_overflow;
   } match_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   pttm_pkg::opcode_type req_opcode = pttm_pkg::OP_TEMPLATE;
   logic [3:0]  req_entry = 0;
   logic        req_code_select = 0;
   logic [8:0]  req_pulse_index = 0;
   logic [19:0] req_pulse_value = 0;
   logic [23:0] req_device_id = 0;
   logic [6:0]  req_tolerance = 0;
   logic [9:0]  req_code_length = 0;
   logic        req_last_pulse = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_found;
   logic [3:0]  rsp_matched_entry;
   logic [23:0] rsp_device_id_out;
   logic        rsp_switch_on;
   logic        rsp_frame_overflow;

   // predictor copy of the block's tables
   logic [19:0] tmpl_mem [0:CODES*MAXP-1];
   bit          tmpl_written [0:CODES*MAXP-1];
   int          written_prefix [0:CODES-1];
   logic [23:0] dev_ids [0:pttm_pkg::ENTRIES_DEF-1];
   logic [6:0]  tols [0:pttm_pkg::ENTRIES_DEF-1];
   int          code_lens [0:CODES-1];
   bit          miss_marks [0:CODES-1];
   int          frame_cnt;
   bit          overflow_seen;

   match_result_type expected_matches[$];
   int  failures = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   pulse_train_template_matcher DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit pulses_agree(logic [19:0] a, logic [19:0] b, logic [6:0] tol);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (hi == 0) return 1;
      return 100 * lo > (99 - longint'(tol)) * hi;
   endfunction

   function automatic void predictor_reset();
      for (int c = 0; c < CODES; c++) begin
         code_lens[c] = 0;
         miss_marks[c] = 0;
         written_prefix[c] = 0;
      end
      for (int e = 0; e < pttm_pkg::ENTRIES_DEF; e++) begin
         dev_ids[e] = 0;
         tols[e] = 7'(pttm_pkg::DEFAULT_TOL);
      end
      frame_cnt = 0;
      overflow_seen = 0;
   endfunction

   function automatic void predict_word(pttm_pkg::opcode_type op, logic [3:0] ent, logic sel,
         logic [8:0] idx, logic [19:0] val, logic [23:0] dev, logic [6:0] tol,
         logic [9:0] len, logic last);
      int c, p, a;
      logic [19:0] t;
      match_result_type r;
      c = 2 * ent + sel;
      case (op)
         pttm_pkg::OP_TEMPLATE: begin
            a = c * MAXP + idx;
            tmpl_mem[a] = val;
            tmpl_written[a] = 1;
            while (written_prefix[c] < MAXP && tmpl_written[c * MAXP + written_prefix[c]])
               written_prefix[c]++;
         end
         pttm_pkg::OP_ATTR: begin
            dev_ids[ent] = dev;
            tols[ent] = tol;
            code_lens[c] = len;
         end
         pttm_pkg::OP_PULSE: begin
            p = frame_cnt;
            if (p >= MAXP) overflow_seen = 1;
            else begin
               for (int k = 0; k < CODES; k++) begin
                  if (p < code_lens[k]) begin
                     t = tmpl_mem[k * MAXP + p];
                     if (!(last && p + 1 == code_lens[k] &&
                           (t > pttm_pkg::FOOTER_LIMIT || val > pttm_pkg::FOOTER_LIMIT)) &&
                         !pulses_agree(t, val, tols[k >> 1]))
                        miss_marks[k] = 1;
                  end
               end
               frame_cnt = p + 1;
            end
            if (last) begin
               r = '0;
               r.frame_overflow = overflow_seen;
               if (!overflow_seen) begin
                  for (int e = 0; e < pttm_pkg::ENTRIES_DEF && !r.found; e++) begin
                     for (int s = 1; s >= 0 && !r.found; s--) begin
                        if (code_lens[2 * e + s] == frame_cnt && !miss_marks[2 * e + s]) begin
                           r.found = 1;
                           r.matched_entry = 4'(e);
                           r.device_id_out = dev_ids[e];
                           r.switch_on = 1'(s);
                        end
                     end
                  end
               end
               expected_matches.push_back(r);
               for (int k = 0; k < CODES; k++) miss_marks[k] = 0;
               frame_cnt = 0;
               overflow_seen = 0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(pttm_pkg::opcode_type op, logic [3:0] ent, logic sel,
         logic [8:0] idx, logic [19:0] val, logic [23:0] dev, logic [6:0] tol,
         logic [9:0] len, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_entry <= ent;
      req_code_select <= sel;
      req_pulse_index <= idx;
      req_pulse_value <= val;
      req_device_id <= dev;
      req_tolerance <= tol;
      req_code_length <= len;
      req_last_pulse <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_word(op, ent, sel, idx, val, dev, tol, len, last);
   endtask

   function automatic logic [19:0] pick_pulse();
      case ($urandom_range(9))
         0: return 20'd0;
         1: return 20'($urandom);
         2: return 20'($urandom_range(30000, 10000));
         default: return 20'($urandom_range(3000, 100));
      endcase
   endfunction

   task automatic write_template(int c, int idx, logic [19:0] val);
      send_word(pttm_pkg::OP_TEMPLATE, 4'(c / 2), 1'(c % 2), 9'(idx), val, 24'($urandom),
                7'($urandom), 10'($urandom), 1'($urandom));
   endtask

   task automatic write_attr(int ent, int sel, logic [23:0] dev, logic [6:0] tol, int len);
      send_word(pttm_pkg::OP_ATTR, 4'(ent), 1'(sel), 9'($urandom), 20'($urandom), dev, tol,
                10'(len), 1'($urandom));
   endtask

   task automatic send_pulse(logic [19:0] val, logic last);
      send_word(pttm_pkg::OP_PULSE, 4'($urandom), 1'($urandom), 9'($urandom), val,
                24'($urandom), 7'($urandom), 10'($urandom), last);
   endtask

   task automatic send_unused();
      send_word(pttm_pkg::OP_UNUSED, 4'($urandom), 1'($urandom), 9'($urandom),
                20'($urandom), 24'($urandom), 7'($urandom), 10'($urandom), 1'($urandom));
   endtask

   // replays the stored code of c with jitter, or random pulses when noisy or past its written part
   task automatic send_frame(int c, int n, bit noisy);
      logic [19:0] t, v;
      int j;
      for (int p = 0; p < n; p++) begin
         if (!noisy && p < written_prefix[c]) begin
            t = tmpl_mem[c * MAXP + p];
            j = (t * tols[c / 2]) / 400;
            v = ($urandom_range(1) && t > j) ? 20'(t - $urandom_range(j)) :
                                               20'(t + $urandom_range(j));
         end else v = pick_pulse();
         if ($urandom_range(99) < 3)
            write_template($urandom_range(CODES - 1), $urandom_range(8), pick_pulse());
         send_pulse(v, p == n - 1);
      end
   endtask

   task automatic test_defaults;
      send_pulse(20'd400, 1'b1);
      send_unused();
      send_pulse(20'hFFFFF, 1'b1);
   endtask

   task automatic test_directed_matches;
      write_template(0, 0, 20'd500);
      write_template(0, 1, 20'd1000);
      write_attr(0, 0, 24'hFFFFFF, 7'd30, 2);
      send_frame(0, 2, 0);
      write_template(1, 0, 20'd500);
      write_template(1, 1, 20'd1000);
      write_attr(0, 1, 24'h5A5A5A, 7'd0, 2);
      send_pulse(20'd500, 1'b0);
      send_pulse(20'd1000, 1'b1);
      send_pulse(20'd505, 1'b0);
      send_pulse(20'd1000, 1'b1);
      write_template(2, 0, 20'd0);
      write_template(2, 1, 20'd12000);
      write_attr(1, 0, 24'h123456, 7'd100, 2);
      send_pulse(20'd0, 1'b0);
      send_pulse(20'd5000, 1'b1);
      write_attr(1, 0, 24'h123456, 7'd0, 2);
      send_pulse(20'd0, 1'b0);
      send_pulse(20'd9000, 1'b1);
      send_pulse(20'd1, 1'b0);
      send_pulse(20'd12000, 1'b1);
   endtask

   task automatic test_overflow;
      send_frame(0, MAXP + 1, 1);
   endtask

   task automatic test_random(int sender_idle, int receiver_stall, int budget);
      int sent, c, n, cap, cand[$];
      send_idle_pct = sender_idle;
      recv_stall_pct = receiver_stall;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4: begin
               c = $urandom_range(CODES - 1);
               n = written_prefix[c];
               write_template(c, (n < MAXP && $urandom_range(2) != 0) ? n : $urandom_range(n),
                              pick_pulse());
               sent++;
            end
            5, 6, 7: begin
               c = $urandom_range(CODES - 1);
               cap = (written_prefix[c] < 12) ? written_prefix[c] : 12;
               n = $urandom_range(cap);
               if (written_prefix[c] == MAXP && $urandom_range(9) == 0)
                  n = $urandom_range(1023, MAXP - 2);
               write_attr(c / 2, c % 2, 24'($urandom), 7'($urandom_range(100)), n);
               sent++;
            end
            8: send_unused();
            default: begin
               cand.delete();
               for (int k = 0; k < CODES; k++)
                  if (code_lens[k] > 0 && code_lens[k] <= 16) cand.push_back(k);
               if (cand.size() == 0 || $urandom_range(9) == 0) begin
                  n = $urandom_range(6, 1);
                  send_frame(0, n, 1);
               end else begin
                  c = cand[$urandom_range(cand.size() - 1)];
                  n = code_lens[c];
                  if ($urandom_range(9) == 0) n = n + 1;
                  send_frame(c, n, $urandom_range(5) == 0);
               end
               sent += n;
            end
         endcase
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure;
      hold_request = 1;
      for (int k = 0; k < 8; k++) send_frame(0, $urandom_range(3, 1), 1);
      req_valid <= 0;
      wait (expected_matches.size() == 0);
      @(posedge clock);
      send_frame(0, 2, 0);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_request != 0) begin
         hold_request = 0;
         hold_left <= 400;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void check_field(string name, logic [23:0] exp, logic [23:0] act);
      if (exp !== act) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp, act);
         failures++;
      end
   endfunction

   always @(negedge clock) begin
      match_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t mismatch unexpected word expected none actual %0h", $time,
                     {rsp_found, rsp_matched_entry, rsp_device_id_out, rsp_switch_on,
                      rsp_frame_overflow});
            failures++;
         end else begin
            e = expected_matches.pop_front();
            check_field("found", 24'(e.found), 24'(rsp_found));
            check_field("matched_entry", 24'(e.matched_entry), 24'(rsp_matched_entry));
            check_field("device_id_out", e.device_id_out, rsp_device_id_out);
            check_field("switch_on", 24'(e.switch_on), 24'(rsp_switch_on));
            check_field("frame_overflow", 24'(e.frame_overflow), 24'(rsp_frame_overflow));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      predictor_reset();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_defaults();
      test_directed_matches();
      test_overflow();
      test_random(19, 52, 120);
      test_random(52, 19, 120);
      test_random(0, 0, 110);
      test_backpressure();
      req_valid <= 0;
      wait (expected_matches.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_matches.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
